>>> hw/rtl/aps_pkg.sv
// Shared types and constants for the allpass phaser with sweep.
package aps_pkg;

  localparam int SweepBits = 40;
  localparam int FactorBits = 31;
  localparam int GainBits = 16;
  localparam int CoefBits = 24;
  localparam int MemBits = 32;
  localparam int CfgIdxBits = 3;
  localparam int SampleBits = 24;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MIN_SWEEP = 3'd0,
    CFG_MAX_SWEEP = 3'd1,
    CFG_UP_FACTOR = 3'd2,
    CFG_DOWN_FACTOR = 3'd3,
    CFG_FEEDBACK = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] right_in;
    logic signed [SampleBits-1:0] left_in;
  } in_req_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] right_out;
    logic signed [SampleBits-1:0] left_out;
  } out_req_t;

  // Control from the sequencer to the lanes.
  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

>>> hw/rtl/aps_coef_div.sv
// Restoring divider that forms the allpass coefficient from the sweep.
module aps_coef_div import aps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SweepBits-1:0] sweep_i,
  output logic                 done_o,
  output logic [CoefBits-1:0]  coef_o
);

  localparam int NumBits = SweepBits + 1 + 23;
  localparam int CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0]     num_q;
  logic [SweepBits+1:0]   den_q;
  logic [SweepBits+1:0]   rem_q;
  logic [CntBits-1:0]     cnt_q;
  logic                   busy_q;
  logic [SweepBits+2:0]   trial;

  assign trial = {rem_q, num_q[NumBits-1]} - {1'b0, den_q};
  assign coef_o = num_q[CoefBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CntBits'(NumBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {({1'b1, {SweepBits{1'b0}}} - {1'b0, sweep_i}), 23'd0};
      den_q <= {1'b0, ({1'b1, {SweepBits{1'b0}}} + {1'b0, sweep_i})};
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[SweepBits+2]) begin
        rem_q <= trial[SweepBits+1:0];
        num_q <= {num_q[NumBits-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[SweepBits:0], num_q[NumBits-1]};
        num_q <= {num_q[NumBits-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hw/rtl/aps_lane.sv
// One channel lane: feedback, allpass stages stepped one per cycle while step is high.
module aps_lane import aps_pkg::*; #(
  parameter int STAGES = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lane_ctrl_t                    ctrl_i,
  input  logic [$clog2(STAGES+1)-1:0]   stage_i,
  input  logic [CoefBits-1:0]           coef_i,
  input  logic signed [GainBits-1:0]    gain_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  output logic signed [SAMPLE_BITS-1:0] out_o
);

  localparam logic signed [MemBits:0] Max32 = (MemBits+1)'(33'sh0_7FFF_FFFF);
  localparam logic signed [MemBits:0] Min32 = -Max32 - 1;
  localparam int SIdx = (STAGES > 1) ? $clog2(STAGES) : 1;

  logic signed [MemBits-1:0] xm_q [STAGES];
  logic signed [MemBits-1:0] ym_q [STAGES];
  logic signed [MemBits-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;

  logic signed [GainBits+MemBits-1:0] fbp;
  logic signed [MemBits+1:0] t_sum;
  logic signed [MemBits-1:0] t_sat;
  logic [SIdx-1:0] si;
  logic signed [MemBits:0] ysum;
  logic signed [MemBits+CoefBits+1:0] prod;
  logic signed [MemBits+3:0] ydiff;
  logic signed [MemBits-1:0] y_sat;
  logic signed [MemBits+1:0] osum;
  logic signed [MemBits+1:0] omax, omin;

  assign si = SIdx'(stage_i);
  assign fbp = gain_i * ym_q[STAGES-1];
  assign t_sum = (MemBits+2)'(smp_i) + (MemBits+2)'(fbp >>> 15);
  assign t_sat = (t_sum > (MemBits+2)'(Max32)) ? Max32[MemBits-1:0] :
                 (t_sum < (MemBits+2)'(Min32)) ? Min32[MemBits-1:0] :
                 t_sum[MemBits-1:0];
  assign ysum = (MemBits+1)'(ym_q[si]) + (MemBits+1)'(x_q);
  assign prod = $signed({1'b0, coef_i}) * ysum;
  assign ydiff = (MemBits+4)'(prod >>> 23) - (MemBits+4)'(xm_q[si]);
  assign y_sat = (ydiff > (MemBits+4)'(Max32)) ? Max32[MemBits-1:0] :
                 (ydiff < (MemBits+4)'(Min32)) ? Min32[MemBits-1:0] :
                 ydiff[MemBits-1:0];
  assign omax = (MemBits+2)'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  assign omin = -omax - 1;
  assign osum = (MemBits+2)'(smp_q) + (MemBits+2)'(ym_q[STAGES-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) begin
        xm_q[k] <= '0;
        ym_q[k] <= '0;
      end
    end else if (ctrl_i.step) begin
      xm_q[si] <= x_q;
      ym_q[si] <= y_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= t_sat;
      smp_q <= smp_i;
    end else if (ctrl_i.step) begin
      x_q <= y_sat;
    end
  end

  assign out_o = (osum > omax) ? omax[SAMPLE_BITS-1:0] :
                 (osum < omin) ? omin[SAMPLE_BITS-1:0] : osum[SAMPLE_BITS-1:0];

endmodule

>>> hw/rtl/allpass_phaser_with_sweep.sv
// Top level of the stereo allpass phaser with exponential sweep.
// Usage: offer a stereo sample pair on in_valid_i/in_ready_o; the result
// pair appears on out_valid_o/out_ready_i. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them
// only while the block is idle, which the block itself does not enforce.
// One request is processed at a time. The coefficient comes from a
// one-bit-per-cycle divider whose done pulse also loads the lanes, then
// each lane runs its stages one per cycle, then the sweep update
// multiplies in the ST_SCALE state and then in the ST_SWEEP state.
// Both channels are processed in parallel lanes and merged into one
// result register. The result stays in that register until taken; a
// stalled receiver holds the block after that request with in_ready_o low.
// Reset clears the allpass state, loads the register defaults and sets
// the sweep to the minimum, rising.
module allpass_phaser_with_sweep import aps_pkg::*; #(
  parameter int CHANNELS = 2,
  parameter int STAGES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_req_t              out_req_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [SweepBits-1:0]  cfg_data_i
);

  localparam int StBits = $clog2(STAGES + 1);
  localparam int LoBits = 20;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_RUN, ST_SCALE, ST_SWEEP, ST_OUT
  } state_e;

  state_e state_q;
  logic [SweepBits-1:0] min_q, max_q, sweep_q;
  logic [FactorBits-1:0] up_q, down_q;
  logic signed [GainBits-1:0] gain_q;
  logic rising_q;
  logic [StBits-1:0] stage_q;
  logic [CoefBits-1:0] coef, coef_q;
  logic div_done;
  logic [1:0][SampleBits-1:0] smp, lout;
  lane_ctrl_t ctrl;
  logic [FactorBits-1:0] fac;
  logic [LoBits+FactorBits-1:0] splo_q;
  logic [SweepBits-LoBits+FactorBits-1:0] sphi;
  logic [SweepBits+FactorBits-1:0] sprod;
  logic [SweepBits+FactorBits-31:0] snew;
  logic [SweepBits-1:0] s_sat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign smp[0] = SampleBits'(in_req_i.left_in);
  assign smp[1] = SampleBits'(in_req_i.right_in);

  always_comb begin
    ctrl.load = (state_q == ST_DIV) && div_done;
    ctrl.step = (state_q == ST_RUN);
  end

  aps_coef_div u_div (
    .clk_i, .rst_ni,
    .start_i(in_valid_i && in_ready_o),
    .sweep_i(sweep_q),
    .done_o(div_done),
    .coef_o(coef)
  );

  assign fac = rising_q ? up_q : down_q;

  logic [1:0][SampleBits-1:0] smp_hold_q;
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) smp_hold_q <= smp;
    if (div_done) coef_q <= coef;
    if (state_q == ST_SCALE) splo_q <= sweep_q[LoBits-1:0] * fac;
  end

  for (genvar c = 0; c < 2; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      aps_lane #(.STAGES(STAGES), .SAMPLE_BITS(SampleBits)) u_lane (
        .clk_i, .rst_ni,
        .ctrl_i(ctrl),
        .stage_i(stage_q),
        .coef_i(ctrl.load ? coef : coef_q),
        .gain_i(gain_q),
        .smp_i($signed(smp_hold_q[c])),
        .out_o(lout[c])
      );
    end else begin : g_off
      assign lout[c] = '0;
    end
  end

  assign sphi = sweep_q[SweepBits-1:LoBits] * fac;
  assign sprod = {sphi, {LoBits{1'b0}}} + (SweepBits+FactorBits)'(splo_q);
  assign snew = sprod[SweepBits+FactorBits-1:30];
  assign s_sat = (|snew[SweepBits+FactorBits-31:SweepBits]) ? '1 : snew[SweepBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      min_q <= SweepBits'(40'd7832590);
      max_q <= SweepBits'(40'd250642880);
      up_q <= FactorBits'(31'd1073809332);
      down_q <= FactorBits'(31'd1073674320);
      gain_q <= GainBits'(16'sd22938);
      sweep_q <= SweepBits'(40'd7832590);
      rising_q <= 1'b1;
      stage_q <= '0;
      out_valid_o <= 1'b0;
      out_req_o <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_SWEEP: min_q <= cfg_data_i;
          CFG_MAX_SWEEP: max_q <= cfg_data_i;
          CFG_UP_FACTOR: up_q <= cfg_data_i[FactorBits-1:0];
          CFG_DOWN_FACTOR: down_q <= cfg_data_i[FactorBits-1:0];
          CFG_FEEDBACK: gain_q <= cfg_data_i[GainBits-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_DIV;
        ST_DIV: if (div_done) begin
          state_q <= ST_RUN;
          stage_q <= '0;
        end
        ST_RUN: begin
          stage_q <= stage_q + 1'b1;
          if (stage_q == StBits'(STAGES - 1)) state_q <= ST_SCALE;
        end
        ST_SCALE: state_q <= ST_SWEEP;
        ST_SWEEP: begin
          sweep_q <= s_sat;
          if (s_sat > max_q) rising_q <= 1'b0;
          else if (s_sat < min_q) rising_q <= 1'b1;
          out_req_o.left_out <= lout[0];
          out_req_o.right_out <= lout[1];
          out_valid_o <= 1'b1;
          state_q <= ST_OUT;
        end
        ST_OUT: if (out_ready_i) begin
          out_valid_o <= 1'b0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
